[src/itoa_pkg.sv]
// ============================================================================
// itoa_pkg
// Shared widths, character codes and register indexes for the integer to
// text converter.
// ============================================================================
package itoa_pkg;

    // Field and register widths
    localparam int NUMBER_W  = 64;
    localparam int RADIX_W   = 6;
    localparam int MINW_W    = 7;
    localparam int CHAR_W    = 8;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    // Longest text the block ever produces
    localparam logic [MINW_W-1:0] MAX_CHARS = 7'd64;

    // Register reset values
    localparam logic [RADIX_W-1:0] RADIX_RST = 6'd10;
    localparam logic [MINW_W-1:0]  MINW_RST  = 7'd0;
    localparam logic [CHAR_W-1:0]  FILL_RST  = 8'd48;

    // Radix limits
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [RADIX_W-1:0] DIGIT_MAX_DEC = 6'd9;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_RADIX = 2'd0;
    localparam logic [1:0] REG_MINW  = 2'd1;
    localparam logic [1:0] REG_FILL  = 2'd2;

    // Map one digit value to its character
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {2'b00, d};
        if (d > DIGIT_MAX_DEC)
            return d_ext - 8'd10 + CHAR_UPPER;
        else
            return d_ext + CHAR_ZERO;
    endfunction

endpackage

[src/itoa_if.sv]
// ============================================================================
// itoa_if
// Request channels of the converter: integer in, characters out.
// ============================================================================
interface itoa_num_if import itoa_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [NUMBER_W-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface itoa_txt_if import itoa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              is_last;
    logic              ok;

    modport source (output valid, output text_char, output is_last, output ok, input ready);
    modport sink   (input valid, input text_char, input is_last, input ok, output ready);
endinterface

[src/integer_to_ascii_radix.sv]
// ============================================================================
// integer_to_ascii_radix
// Converts one integer to text in a configured base, most significant
// character first, left padded to a configured minimum width.
// ============================================================================
//
//  channel | dir | payload                   | request moves
//  --------+-----+---------------------------+---------------------------------
//  num     | in  | number[63:0] signed       | one integer to convert
//  txt     | out | text_char[7:0], is_last,  | one character of the text
//          |     | ok                        |
//  apb     | in  | radix, min_width, fill    | register write / read
//
//  A bad radix gives one error request. Otherwise the shared bit-serial
//  divider works out the digits one by one into the digit store, then the
//  pad and sign characters are loaded, and each digit is sent through a
//  digit store read, then an output load.
//  The block takes no new integer until the last character is loaded.
//  A stalled output holds its register and the sequencer waits on it.
//  Reset is asynchronous and clears control and registers; the digit store
//  needs no clearing pass.
// ============================================================================
module integer_to_ascii_radix import itoa_pkg::*; #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    itoa_num_if.sink           num,
    itoa_txt_if.source         txt
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int IDX_W = $clog2(VALUE_WIDTH);
    localparam int BIT_W = $clog2(VALUE_WIDTH);
    localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(VALUE_WIDTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PAD,
        S_SIGN,
        S_READ,
        S_DIGIT,
        S_ERR
    } state_t;

    // Configuration registers
    logic [RADIX_W-1:0] radix_reg;
    logic [MINW_W-1:0]  min_width_reg;
    logic [CHAR_W-1:0]  fill_char_reg;
    logic               cfg_wr;
    logic [1:0]         cfg_idx;

    // Sequencer and datapath registers
    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [RADIX_W-1:0]     rem_reg, rem_next;
    logic [BIT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]       dcnt_reg, dcnt_next;
    logic [MINW_W-1:0]      pad_reg, pad_next;
    logic                   neg_reg, neg_next;

    // Output register
    logic              txt_valid_reg, txt_valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;
    logic              ok_reg, ok_next;

    // Digit store
    logic [RADIX_W-1:0] digit_mem [VALUE_WIDTH];
    logic [RADIX_W-1:0] rd_reg;
    logic               mem_we;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_waddr;
    logic [IDX_W-1:0]   mem_raddr;

    // Combinational helpers
    logic [VALUE_WIDTH-1:0] in_val;
    logic                   in_neg;
    logic                   radix_bad;
    logic [RADIX_W:0]       trial;
    logic [RADIX_W:0]       diff;
    logic                   ge;
    logic [RADIX_W-1:0]     rem_step;
    logic [VALUE_WIDTH-1:0] quo_step;
    logic [CNT_W-1:0]       dcnt_inc;
    logic [CNT_W-1:0]       dcnt_dec;
    logic [MINW_W-1:0]      text_len;
    logic [MINW_W-1:0]      width_cap;
    logic [MINW_W-1:0]      pad_calc;
    logic                   out_free;

    // ------------------------------------------------------------------------
    // APB register port
    // ------------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        case (cfg_idx)
            REG_RADIX: prdata = PDATA_W'(radix_reg);
            REG_MINW:  prdata = PDATA_W'(min_width_reg);
            REG_FILL:  prdata = PDATA_W'(fill_char_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= RADIX_RST;
            min_width_reg <= MINW_RST;
            fill_char_reg <= FILL_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_RADIX: radix_reg     <= pwdata[RADIX_W-1:0];
                REG_MINW:  min_width_reg <= pwdata[MINW_W-1:0];
                REG_FILL:  fill_char_reg <= pwdata[CHAR_W-1:0];
                default:   ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Shared divider step: one quotient bit a cycle
    // ------------------------------------------------------------------------
    assign trial    = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign diff     = trial - {1'b0, radix_reg};
    assign ge       = (trial >= {1'b0, radix_reg});
    assign rem_step = ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
    assign quo_step = {quo_reg[VALUE_WIDTH-2:0], ge};

    // Input decode
    assign in_val    = num.number[VALUE_WIDTH-1:0];
    assign radix_bad = (radix_reg < RADIX_MIN) || (radix_reg > RADIX_MAX);
    assign in_neg    = (radix_reg == RADIX_DEC) && in_val[VALUE_WIDTH-1];

    // Padding length once the last digit is known
    assign dcnt_inc  = dcnt_reg + 1'b1;
    assign dcnt_dec  = dcnt_reg - 1'b1;
    assign text_len  = MINW_W'(dcnt_inc) + MINW_W'(neg_reg);
    assign width_cap = (min_width_reg > MAX_CHARS) ? MAX_CHARS : min_width_reg;
    assign pad_calc  = (width_cap > text_len) ? (width_cap - text_len) : '0;

    assign out_free  = !txt_valid_reg || txt.ready;

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        bit_cnt_next   = bit_cnt_reg;
        dcnt_next      = dcnt_reg;
        pad_next       = pad_reg;
        neg_next       = neg_reg;
        txt_valid_next = txt_valid_reg && !txt.ready;
        char_next      = char_reg;
        last_next      = last_reg;
        ok_next        = ok_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = dcnt_reg[IDX_W-1:0];
        mem_raddr      = dcnt_dec[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (num.valid)
                begin
                    if (radix_bad)
                        state_next = S_ERR;
                    else
                    begin
                        state_next   = S_DIV;
                        neg_next     = in_neg;
                        quo_next     = in_neg ? (~in_val + 1'b1) : in_val;
                        rem_next     = '0;
                        bit_cnt_next = BIT_TOP;
                        dcnt_next    = '0;
                    end
                end
            end

            S_DIV:
            begin
                quo_next     = quo_step;
                rem_next     = rem_step;
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    // store the digit and start the next one
                    mem_we       = 1'b1;
                    dcnt_next    = dcnt_inc;
                    rem_next     = '0;
                    bit_cnt_next = BIT_TOP;
                    if (quo_step == '0)
                    begin
                        pad_next = pad_calc;
                        if (pad_calc != '0)
                            state_next = S_PAD;
                        else if (neg_reg)
                            state_next = S_SIGN;
                        else
                            state_next = S_READ;
                    end
                end
            end

            S_PAD:
            begin
                if (out_free)
                begin
                    txt_valid_next = 1'b1;
                    char_next      = fill_char_reg;
                    last_next      = 1'b0;
                    ok_next        = 1'b1;
                    pad_next       = pad_reg - 1'b1;
                    if (pad_reg == MINW_W'(1))
                        state_next = neg_reg ? S_SIGN : S_READ;
                end
            end

            S_SIGN:
            begin
                if (out_free)
                begin
                    txt_valid_next = 1'b1;
                    char_next      = CHAR_MINUS;
                    last_next      = 1'b0;
                    ok_next        = 1'b1;
                    state_next     = S_READ;
                end
            end

            S_READ:
            begin
                mem_re     = 1'b1;
                state_next = S_DIGIT;
            end

            S_DIGIT:
            begin
                if (out_free)
                begin
                    txt_valid_next = 1'b1;
                    char_next      = digit_to_char(rd_reg);
                    last_next      = (dcnt_reg == CNT_W'(1));
                    ok_next        = 1'b1;
                    dcnt_next      = dcnt_dec;
                    state_next     = (dcnt_reg == CNT_W'(1)) ? S_IDLE : S_READ;
                end
            end

            S_ERR:
            begin
                if (out_free)
                begin
                    txt_valid_next = 1'b1;
                    char_next      = CHAR_NUL;
                    last_next      = 1'b1;
                    ok_next        = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            quo_reg       <= '0;
            rem_reg       <= '0;
            bit_cnt_reg   <= '0;
            dcnt_reg      <= '0;
            pad_reg       <= '0;
            neg_reg       <= 1'b0;
            txt_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
            ok_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            bit_cnt_reg   <= bit_cnt_next;
            dcnt_reg      <= dcnt_next;
            pad_reg       <= pad_next;
            neg_reg       <= neg_next;
            txt_valid_reg <= txt_valid_next;
            char_reg      <= char_next;
            last_reg      <= last_next;
            ok_reg        <= ok_next;
        end
    end

    // Digit store: write one digit, read one digit
    always_ff @(posedge clk)
    begin
        if (mem_we)
            digit_mem[mem_waddr] <= rem_step;
        if (mem_re)
            rd_reg <= digit_mem[mem_raddr];
    end

    // Drive the channels
    assign num.ready     = (state_reg == S_IDLE);
    assign txt.valid     = txt_valid_reg;
    assign txt.text_char = char_reg;
    assign txt.is_last   = last_reg;
    assign txt.ok        = ok_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // Busy in the cycle after taking an integer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        num.valid && num.ready |=> !num.ready)
        else $error("input taken again straight after an accept");

    // The error request is always the only and last one
    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        txt.valid && !txt.ok |-> txt.is_last && (txt.text_char == CHAR_NUL))
        else $error("error request not marked last");

    // Digit count stays within the store
    a_dcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        dcnt_reg <= CNT_W'(VALUE_WIDTH))
        else $error("digit count beyond store depth");

    // Pending output is not overwritten while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        txt.valid && !txt.ready |=> txt.valid && $stable(char_reg) && $stable(last_reg))
        else $error("stalled character changed");

endmodule
